// ===== design/hms_pkg.sv =====
// ----------------------------------------------------------------------------
// Height map sampler package
// Shared sizes, configuration register codes and the types that travel
// between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package hms_pkg;

    // Store geometry and sample width.
    localparam int MAP_DIM     = 256;
    localparam int HEIGHT_BITS = 24;
    localparam int CELL_W      = $clog2(MAP_DIM);
    localparam int BANK_DEPTH  = MAP_DIM * MAP_DIM / 4;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);

    // Field and arithmetic widths.
    localparam int SIZE_W      = 9;
    localparam int FRAC_W      = 16;
    localparam int ROW_W       = HEIGHT_BITS + FRAC_W;
    localparam int SCALE_W     = 32;

    // Queue depths.
    localparam int MID_DEPTH   = 8;
    localparam int OUT_DEPTH   = 8;

    // Configuration port.
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [SCALE_W-1:0] INV_SCALE_RST = 32'd65536;
    localparam logic [SIZE_W-1:0]  SIZE_RST      = 9'd256;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_INV_SCALE = 2'd0,
        CFG_MAP_WIDTH = 2'd1,
        CFG_MAP_DEPTH = 2'd2
    } t_cfg_reg;

    // Effective configuration seen by the coordinate mapping.
    typedef struct packed {
        logic [SCALE_W-1:0] inv_scale;
        logic [SIZE_W-1:0]  size_x;
        logic [SIZE_W-1:0]  size_z;
    } t_cfg;

    // One classified word between the front end and the back end.
    typedef struct packed {
        logic                   is_query;
        logic                   wr_ok;
        logic [CELL_W-1:0]      cell_x;
        logic [CELL_W-1:0]      cell_z;
        logic [FRAC_W-1:0]      frac_x;
        logic [FRAC_W-1:0]      frac_z;
        logic [HEIGHT_BITS-1:0] value;
    } t_mid_item;

endpackage

// ===== design/hms_front.sv =====
// ----------------------------------------------------------------------------
// Height map sampler front end
// Classifies each accepted word and maps query positions to a cell index
// and a 16-bit fraction per axis over two register stages.
// ----------------------------------------------------------------------------
module hms_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_action,
    input  logic [7:0]                        i_cell_x,
    input  logic [7:0]                        i_cell_z,
    input  logic [23:0]                       i_sample_value,
    input  logic signed [31:0]                i_pos_x,
    input  logic signed [31:0]                i_pos_z,
    input  hms_pkg::t_cfg                     i_cfg,
    output logic                              o_valid,
    output hms_pkg::t_mid_item                o_item
);
    import hms_pkg::*;

    localparam int PROD_W = 65;
    localparam int U_W    = 36;
    localparam int M_W    = 46;

    localparam logic signed [PROD_W-1:0] U_LIM    = 65'sd17179869184;
    localparam logic signed [U_W-1:0]    U_LIM_S  = 36'sd17179869184;
    localparam logic signed [U_W-1:0]    U_HALF   = 36'sd2147483648;
    localparam logic signed [M_W-1:0]    M_HALF   = 46'sd2147483648;

    typedef struct packed {
        logic [CELL_W-1:0] idx;
        logic [FRAC_W-1:0] frac;
    } t_axis;

    // Clamp the scaled position, add one half and multiply by the map size.
    function automatic logic signed [M_W-1:0] scale_axis(
        input logic signed [PROD_W-1:0] prod,
        input logic [SIZE_W-1:0]        size
    );
        logic signed [U_W-1:0]    u;
        logic signed [SIZE_W:0]   s;
        logic signed [M_W-1:0]    m;
        s = $signed({1'b0, size});
        if (prod > U_LIM) begin
            u = U_LIM_S;
        end else if (prod < -U_LIM) begin
            u = -U_LIM_S;
        end else begin
            u = prod[U_W-1:0];
        end
        u = u + U_HALF;
        m = u * s;
        return m;
    endfunction

    // Add one half, clamp into the map and split into cell and fraction.
    function automatic t_axis split_axis(
        input logic signed [M_W-1:0] m_raw,
        input logic [SIZE_W-1:0]     size
    );
        logic signed [M_W-1:0] m;
        logic signed [M_W-1:0] hi_lim;
        t_axis                 a;
        m      = m_raw + M_HALF;
        hi_lim = $signed({5'b0, size - SIZE_W'(1), 32'b0});
        if (m >= hi_lim) begin
            a.idx  = CELL_W'(size - SIZE_W'(2));
            a.frac = '0;
        end else if (m < 0) begin
            a.idx  = '0;
            a.frac = '0;
        end else begin
            a.idx  = m[32 +: CELL_W];
            a.frac = m[16 +: FRAC_W];
        end
        return a;
    endfunction

    logic signed [SCALE_W:0]    inv_s;
    logic signed [PROD_W-1:0]   n_prod_x;
    logic signed [PROD_W-1:0]   n_prod_z;
    logic                       n_wr_ok;

    logic                       r_s1_valid;
    logic                       r_s1_query;
    logic                       r_s1_wr_ok;
    logic [CELL_W-1:0]          r_s1_cell_x;
    logic [CELL_W-1:0]          r_s1_cell_z;
    logic [HEIGHT_BITS-1:0]     r_s1_value;
    logic signed [PROD_W-1:0]   r_s1_prod_x;
    logic signed [PROD_W-1:0]   r_s1_prod_z;

    logic                       r_s2_valid;
    logic                       r_s2_query;
    logic                       r_s2_wr_ok;
    logic [CELL_W-1:0]          r_s2_cell_x;
    logic [CELL_W-1:0]          r_s2_cell_z;
    logic [HEIGHT_BITS-1:0]     r_s2_value;
    logic signed [M_W-1:0]      r_s2_m_x;
    logic signed [M_W-1:0]      r_s2_m_z;

    t_axis                      ax_x;
    t_axis                      ax_z;

    // Position times inverse world scale, exact in Q32.32.
    assign inv_s    = $signed({1'b0, i_cfg.inv_scale});
    assign n_prod_x = i_pos_x * inv_s;
    assign n_prod_z = i_pos_z * inv_s;
    assign n_wr_ok  = (32'(i_cell_x) < MAP_DIM) && (32'(i_cell_z) < MAP_DIM);

    // The pipeline never stalls; the top level holds back words it has no room for.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_query  <= i_action;
        r_s1_wr_ok  <= n_wr_ok;
        r_s1_cell_x <= CELL_W'(i_cell_x);
        r_s1_cell_z <= CELL_W'(i_cell_z);
        r_s1_value  <= HEIGHT_BITS'(i_sample_value);
        r_s1_prod_x <= n_prod_x;
        r_s1_prod_z <= n_prod_z;

        r_s2_query  <= r_s1_query;
        r_s2_wr_ok  <= r_s1_wr_ok;
        r_s2_cell_x <= r_s1_cell_x;
        r_s2_cell_z <= r_s1_cell_z;
        r_s2_value  <= r_s1_value;
        r_s2_m_x    <= scale_axis(r_s1_prod_x, i_cfg.size_x);
        r_s2_m_z    <= scale_axis(r_s1_prod_z, i_cfg.size_z);
    end

    // Final clamp and packing of the queue word.
    always_comb begin
        ax_x            = split_axis(r_s2_m_x, i_cfg.size_x);
        ax_z            = split_axis(r_s2_m_z, i_cfg.size_z);
        o_valid         = r_s2_valid;
        o_item.is_query = r_s2_query;
        o_item.wr_ok    = r_s2_wr_ok;
        o_item.cell_x   = r_s2_query ? ax_x.idx : r_s2_cell_x;
        o_item.cell_z   = r_s2_query ? ax_z.idx : r_s2_cell_z;
        o_item.frac_x   = ax_x.frac;
        o_item.frac_z   = ax_z.frac;
        o_item.value    = r_s2_value;
    end

endmodule

// ===== design/hms_queue.sv =====
// ----------------------------------------------------------------------------
// Height map sampler middle queue
// A short first-in first-out queue of classified words between the front
// end and the back end.
// ----------------------------------------------------------------------------
module hms_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  hms_pkg::t_mid_item  i_item,
    input  logic                i_pop,
    output logic                o_empty,
    output hms_pkg::t_mid_item  o_head
);
    import hms_pkg::*;

    localparam int PTR_W = $clog2(MID_DEPTH);
    localparam int CNT_W = $clog2(MID_DEPTH + 1);

    t_mid_item          r_mem [MID_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;

    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Occupancy follows the push and pop strobes.
    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + CNT_W'(1);
            2'b01:   n_count = r_count - CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== design/hms_back.sv =====
// ----------------------------------------------------------------------------
// Height map sampler back end
// Holds the height store in four banks split by cell parity, so the four
// taps of a query read together, blends them and queues the results.
// ----------------------------------------------------------------------------
module hms_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  hms_pkg::t_mid_item          i_q_head,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [23:0]                 o_height
);
    import hms_pkg::*;

    localparam int HB      = HEIGHT_BITS;
    localparam int OPTR_W  = $clog2(OUT_DEPTH);
    localparam int OCNT_W  = $clog2(OUT_DEPTH + 1);

    // Blend along x: a + (b - a) * f, exact in Q8.32.
    function automatic logic [ROW_W-1:0] row_blend(
        input logic [HB-1:0]     a,
        input logic [HB-1:0]     b,
        input logic [FRAC_W-1:0] f
    );
        logic signed [HB:0]    d;
        logic signed [HB+17:0] p;
        logic signed [HB+17:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, f});
        s = $signed({2'b0, a, 16'b0}) + p;
        return s[ROW_W-1:0];
    endfunction

    // Blend the two rows along z and truncate to Q8.16.
    function automatic logic [HB-1:0] col_blend(
        input logic [ROW_W-1:0]  a,
        input logic [ROW_W-1:0]  b,
        input logic [FRAC_W-1:0] f
    );
        logic signed [ROW_W:0]    d;
        logic signed [ROW_W+17:0] p;
        logic signed [ROW_W+17:0] s;
        d = $signed({1'b0, b}) - $signed({1'b0, a});
        p = d * $signed({1'b0, f});
        s = $signed({2'b0, a, 16'b0}) + p;
        return s[32 +: HB];
    endfunction

    logic                       issue;
    logic                       issue_query;
    logic                       wr_any;
    logic [1:0]                 wr_bank;
    logic [BANK_AW-1:0]         wr_addr;
    logic [HB-1:0]              r_rd_data [4];

    logic                       r_b1_valid;
    logic                       r_b1_px;
    logic                       r_b1_pz;
    logic [FRAC_W-1:0]          r_b1_fx;
    logic [FRAC_W-1:0]          r_b1_fz;

    logic                       r_b2_valid;
    logic [ROW_W-1:0]           r_b2_i1;
    logic [ROW_W-1:0]           r_b2_i2;
    logic [FRAC_W-1:0]          r_b2_fz;

    logic [HB-1:0]              v1;
    logic [HB-1:0]              v2;
    logic [HB-1:0]              v3;
    logic [HB-1:0]              v4;
    logic [HB-1:0]              height_c;

    logic [23:0]                r_of_mem [OUT_DEPTH];
    logic [OPTR_W-1:0]          r_of_wr;
    logic [OPTR_W-1:0]          r_of_rd;
    logic [OCNT_W-1:0]          r_of_count;
    logic [OCNT_W-1:0]          n_of_count;
    logic [OCNT_W-1:0]          r_out_used;
    logic [OCNT_W-1:0]          n_out_used;
    logic                       pop_ok;

    // A write issues at once; a query only while a result slot is free, which it then reserves.
    assign issue       = !i_q_empty &&
                         (!i_q_head.is_query || (r_out_used < OCNT_W'(OUT_DEPTH)));
    assign issue_query = issue && i_q_head.is_query;
    assign wr_any      = issue && !i_q_head.is_query && i_q_head.wr_ok;
    assign wr_bank     = {i_q_head.cell_z[0], i_q_head.cell_x[0]};
    assign wr_addr     = {i_q_head.cell_z[CELL_W-1:1], i_q_head.cell_x[CELL_W-1:1]};
    assign o_q_pop     = issue;

    // Four parity banks; each sees exactly one of the four taps of a query.
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic [1:0] BANK_ID = 2'(b);
        logic [HB-1:0]        r_mem [BANK_DEPTH];
        logic [CELL_W-1:0]    row;
        logic [CELL_W-1:0]    col;
        logic [BANK_AW-1:0]   rd_addr;
        logic                 wr_en;

        assign row     = i_q_head.cell_z + CELL_W'(BANK_ID[1] ^ i_q_head.cell_z[0]);
        assign col     = i_q_head.cell_x + CELL_W'(BANK_ID[0] ^ i_q_head.cell_x[0]);
        assign rd_addr = {row[CELL_W-1:1], col[CELL_W-1:1]};
        assign wr_en   = wr_any && (wr_bank == BANK_ID);

        always_ff @(posedge i_clk) begin
            if (wr_en) begin
                r_mem[wr_addr] <= i_q_head.value;
            end
            r_rd_data[b] <= r_mem[rd_addr];
        end
    end

    // Pipeline valid bits; the back end never stalls once a word issues.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
        end else begin
            r_b1_valid <= issue_query;
            r_b2_valid <= r_b1_valid;
        end
    end

    // Route the bank outputs back to tap order.
    always_comb begin
        v1       = r_rd_data[{r_b1_pz, r_b1_px}];
        v2       = r_rd_data[{r_b1_pz, !r_b1_px}];
        v3       = r_rd_data[{!r_b1_pz, r_b1_px}];
        v4       = r_rd_data[{!r_b1_pz, !r_b1_px}];
        height_c = col_blend(r_b2_i1, r_b2_i2, r_b2_fz);
    end

    always_ff @(posedge i_clk) begin
        r_b1_px <= i_q_head.cell_x[0];
        r_b1_pz <= i_q_head.cell_z[0];
        r_b1_fx <= i_q_head.frac_x;
        r_b1_fz <= i_q_head.frac_z;
        r_b2_i1 <= row_blend(v1, v2, r_b1_fx);
        r_b2_i2 <= row_blend(v3, v4, r_b1_fx);
        r_b2_fz <= r_b1_fz;
    end

    // Result queue and the count of reserved result slots.
    assign pop_ok   = i_pop && !o_empty;
    assign o_empty  = (r_of_count == '0);
    assign o_height = r_of_mem[r_of_rd];

    always_comb begin
        n_of_count = r_of_count;
        case ({r_b2_valid, pop_ok})
            2'b10:   n_of_count = r_of_count + OCNT_W'(1);
            2'b01:   n_of_count = r_of_count - OCNT_W'(1);
            default: n_of_count = r_of_count;
        endcase
        n_out_used = r_out_used;
        case ({issue_query, pop_ok})
            2'b10:   n_out_used = r_out_used + OCNT_W'(1);
            2'b01:   n_out_used = r_out_used - OCNT_W'(1);
            default: n_out_used = r_out_used;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_of_wr    <= '0;
            r_of_rd    <= '0;
            r_of_count <= '0;
            r_out_used <= '0;
        end else begin
            if (r_b2_valid) begin
                r_of_wr <= r_of_wr + OPTR_W'(1);
            end
            if (pop_ok) begin
                r_of_rd <= r_of_rd + OPTR_W'(1);
            end
            r_of_count <= n_of_count;
            r_out_used <= n_out_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b2_valid) begin
            r_of_mem[r_of_wr] <= 24'(height_c);
        end
    end

endmodule

// ===== design/bilinear_heightmap_sampler.sv =====
// ----------------------------------------------------------------------------
// Bilinear height map sampler
// Stores a 256 x 256 height map and returns bilinearly interpolated heights
// for world positions given in signed Q16.16.
//
//   Channel   Direction  Handshake              Word
//   input     in         push / full            action, cell, sample, position
//   result    out        empty / pop            height (one per query)
//   config    in         i_cfg_we, no wait      index, 32-bit data
//
// One word is accepted per cycle while full is low. A query's result
// reaches the result ports through the two mapping stages, the middle
// queue, the bank read, the row blend register and the result queue.
// Reset empties the queues and presets the configuration only; the height
// store has no clearing pass, so a sample reads back only once written.
// full rises once eight words wait between acceptance and the bank issue
// stage; queries issue only while one of the eight result slots is free.
// ----------------------------------------------------------------------------
module bilinear_heightmap_sampler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic                              i_action,
    input  logic [7:0]                        i_cell_x,
    input  logic [7:0]                        i_cell_z,
    input  logic [23:0]                       i_sample_value,
    input  logic signed [31:0]                i_pos_x,
    input  logic signed [31:0]                i_pos_z,
    output logic                              empty,
    input  logic                              pop,
    output logic [23:0]                       o_height,
    input  logic                              i_cfg_we,
    input  logic [hms_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [hms_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import hms_pkg::*;

    localparam int USED_W = $clog2(MID_DEPTH + 1);

    logic [SCALE_W-1:0]  r_inv_scale;
    logic [SIZE_W-1:0]   r_map_width;
    logic [SIZE_W-1:0]   r_map_depth;
    logic [USED_W-1:0]   r_mid_used;
    logic [USED_W-1:0]   n_mid_used;

    t_cfg                cfg;
    logic                accept;
    logic                front_valid;
    t_mid_item           front_item;
    logic                q_empty;
    t_mid_item           q_head;
    logic                q_pop;

    // Map sizes below two act as two, above the store size as the store size.
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        if (s < SIZE_W'(2)) begin
            return SIZE_W'(2);
        end else if (s > SIZE_W'(MAP_DIM)) begin
            return SIZE_W'(MAP_DIM);
        end
        return s;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_scale <= INV_SCALE_RST;
            r_map_width <= SIZE_RST;
            r_map_depth <= SIZE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_INV_SCALE: r_inv_scale <= SCALE_W'(i_cfg_data);
                CFG_MAP_WIDTH: r_map_width <= i_cfg_data[SIZE_W-1:0];
                CFG_MAP_DEPTH: r_map_depth <= i_cfg_data[SIZE_W-1:0];
                default:       ;
            endcase
        end
    end

    assign cfg.inv_scale = r_inv_scale;
    assign cfg.size_x    = eff_size(r_map_width);
    assign cfg.size_z    = eff_size(r_map_depth);

    // Words held between acceptance and issue; this bounds the middle queue.
    assign full   = (r_mid_used == USED_W'(MID_DEPTH));
    assign accept = push && !full;

    always_comb begin
        n_mid_used = r_mid_used;
        case ({accept, q_pop})
            2'b10:   n_mid_used = r_mid_used + USED_W'(1);
            2'b01:   n_mid_used = r_mid_used - USED_W'(1);
            default: n_mid_used = r_mid_used;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_used <= '0;
        end else begin
            r_mid_used <= n_mid_used;
        end
    end

    hms_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (accept),
        .i_action       (i_action),
        .i_cell_x       (i_cell_x),
        .i_cell_z       (i_cell_z),
        .i_sample_value (i_sample_value),
        .i_pos_x        (i_pos_x),
        .i_pos_z        (i_pos_z),
        .i_cfg          (cfg),
        .o_valid        (front_valid),
        .o_item         (front_item)
    );

    hms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    hms_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_height  (o_height)
    );

endmodule

// ===== design/hms_checker.sv =====
// ----------------------------------------------------------------------------
// Height map sampler port checker
// Watches the top level's ports for reset behaviour, result holding and the
// causes of rises in the full and empty flags.
// ----------------------------------------------------------------------------
module hms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [23:0] o_height
);

    // Reset leaves no result waiting and room for input.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("Queues not cleared by reset.");

    // A waiting result that is not taken stays, unchanged.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_height)))
        else $error("Waiting result changed or vanished without a pop.");

    // The block fills up only by accepting a word.
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an accepted word.");

    // The result side runs dry only by a pop.
    a_empty_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(empty) |-> $past(pop))
        else $error("empty rose without a pop.");

endmodule

bind bilinear_heightmap_sampler hms_checker u_hms_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_height (o_height)
);
